### rtl/lbtn_pkg.sv
// Shared types, codes and defaults for the level bucketed top-N keeper.
package lbtn_pkg;

    localparam int unsigned POOL_SIZE_DEF   = 64;
    localparam int unsigned LEVEL_SLOTS_DEF = 64;
    localparam int unsigned SCORE_BITS_DEF  = 32;

    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned OUT_USER_W = 3;

    localparam logic [1:0] MODE_SCORE = 2'd0;
    localparam logic [1:0] MODE_LEVEL = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    localparam logic [1:0] CFG_KEEP   = 2'd0;
    localparam logic [1:0] CFG_LEVELS = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE     = 5'd0;
    localparam t_op OP_LOAD     = 5'd1;
    localparam t_op OP_DIV      = 5'd2;
    localparam t_op OP_LVL      = 5'd3;
    localparam t_op OP_FILL     = 5'd4;
    localparam t_op OP_EVRD     = 5'd5;
    localparam t_op OP_EVICT    = 5'd6;
    localparam t_op OP_EVICT2   = 5'd7;
    localparam t_op OP_CLAMP    = 5'd8;
    localparam t_op OP_ADV      = 5'd9;
    localparam t_op OP_MUL      = 5'd10;
    localparam t_op OP_BASE     = 5'd11;
    localparam t_op OP_CLEAR    = 5'd12;
    localparam t_op OP_RES_INS  = 5'd13;
    localparam t_op OP_RES_CLR  = 5'd14;
    localparam t_op OP_RD_START = 5'd15;
    localparam t_op OP_RD_HEAD  = 5'd16;
    localparam t_op OP_RD_NEXTL = 5'd17;
    localparam t_op OP_RD_NODE  = 5'd18;
    localparam t_op OP_RD_EMIT  = 5'd19;
    localparam t_op OP_RD_END   = 5'd20;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       div_last;
        logic       drop;
        logic       below_cap;
        logic       can_evict;
        logic       ok_low;
        logic       walk;
        logic       ok_rl;
        logic       rl_lt_top;
        logic       node_next_ok;
        logic       pend_valid;
        logic       out_free;
    } t_stat;

endpackage

### rtl/level_bucketed_top_n_keeper.sv
// Top level of the level bucketed approximate top-N keeper.
// Keeps up to keep_count values on per-level linked lists in a node pool and
// takes one item at a time. An insert by score first runs the bit-serial
// divide of score by level_width, then updates the lists and, when the lowest
// occupied level moves up, steps past each empty level. An insert by level
// skips the divide. A readout emits its values as a run closed by tlast,
// paced by the node pool reads. The next item is taken as soon as the last
// result sits in the output register. A write to the keep, levels or width
// register also empties the store.
module level_bucketed_top_n_keeper #(
    parameter int unsigned POOL_SIZE   = lbtn_pkg::POOL_SIZE_DEF,
    parameter int unsigned LEVEL_SLOTS = lbtn_pkg::LEVEL_SLOTS_DEF,
    parameter int unsigned SCORE_BITS  = lbtn_pkg::SCORE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // score[31:0], given_level[37:32], item_value[69:38], zero[71:70]
    input  logic [71:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_value[31:0], out_level[37:32], lowest_level[43:38], zero[47:44]
    output logic [47:0] m_axis_tdata,
    // admitted[0], evicted[1], out_valid[2]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    lbtn_pkg::t_cmd  w_cmd;
    lbtn_pkg::t_stat w_stat;

    lbtn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lbtn_dp #(
        .POOL_SIZE   (POOL_SIZE),
        .LEVEL_SLOTS (LEVEL_SLOTS),
        .SCORE_BITS  (SCORE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tuser  (m_axis_tuser),
        .o_out_tlast  (m_axis_tlast)
    );

endmodule

### rtl/lbtn_ctrl.sv
// Sequencer that steps the keeper datapath through insert, clear and readout.
module lbtn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lbtn_pkg::t_stat  i_stat,
    output lbtn_pkg::t_cmd   o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_DIV     = 5'd2;
    localparam logic [4:0] S_LVL     = 5'd3;
    localparam logic [4:0] S_DEC     = 5'd4;
    localparam logic [4:0] S_FILLCHK = 5'd5;
    localparam logic [4:0] S_EVICT   = 5'd6;
    localparam logic [4:0] S_EVICT2  = 5'd7;
    localparam logic [4:0] S_CLAMP   = 5'd8;
    localparam logic [4:0] S_ADVCHK  = 5'd9;
    localparam logic [4:0] S_WALK    = 5'd10;
    localparam logic [4:0] S_BASE    = 5'd11;
    localparam logic [4:0] S_RES     = 5'd12;
    localparam logic [4:0] S_CLR     = 5'd13;
    localparam logic [4:0] S_RDHEAD  = 5'd14;
    localparam logic [4:0] S_RDHCHK  = 5'd15;
    localparam logic [4:0] S_RDEMIT  = 5'd16;
    localparam logic [4:0] S_RDNEXT  = 5'd17;
    localparam logic [4:0] S_RDEND   = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = lbtn_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = lbtn_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.mode)
                    lbtn_pkg::MODE_SCORE: n_state = S_DIV;
                    lbtn_pkg::MODE_LEVEL: n_state = S_LVL;
                    lbtn_pkg::MODE_CLEAR: begin
                        o_cmd.op = lbtn_pkg::OP_CLEAR;
                        n_state  = S_CLR;
                    end
                    default: begin
                        o_cmd.op = lbtn_pkg::OP_RD_START;
                        n_state  = S_RDHEAD;
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.op = lbtn_pkg::OP_DIV;
                if (i_stat.div_last) n_state = S_LVL;
            end
            S_LVL: begin
                o_cmd.op = lbtn_pkg::OP_LVL;
                n_state  = S_DEC;
            end
            S_DEC: begin
                priority if (i_stat.drop) begin
                    n_state = S_RES;
                end else if (i_stat.below_cap) begin
                    o_cmd.op = lbtn_pkg::OP_FILL;
                    n_state  = S_FILLCHK;
                end else if (i_stat.can_evict) begin
                    o_cmd.op = lbtn_pkg::OP_EVRD;
                    n_state  = S_EVICT;
                end else begin
                    n_state = S_RES;
                end
            end
            S_FILLCHK: n_state = i_stat.below_cap ? S_RES : S_CLAMP;
            S_EVICT: begin
                o_cmd.op = lbtn_pkg::OP_EVICT;
                n_state  = S_EVICT2;
            end
            S_EVICT2: begin
                o_cmd.op = lbtn_pkg::OP_EVICT2;
                n_state  = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.op = lbtn_pkg::OP_CLAMP;
                n_state  = S_ADVCHK;
            end
            S_ADVCHK: n_state = i_stat.ok_low ? S_RES : S_WALK;
            S_WALK: begin
                if (i_stat.walk) begin
                    o_cmd.op = lbtn_pkg::OP_ADV;
                end else begin
                    o_cmd.op = lbtn_pkg::OP_MUL;
                    n_state  = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.op = lbtn_pkg::OP_BASE;
                n_state  = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.op = lbtn_pkg::OP_RES_INS;
                    n_state  = S_IDLE;
                end
            end
            S_CLR: begin
                if (i_stat.out_free) begin
                    o_cmd.op = lbtn_pkg::OP_RES_CLR;
                    n_state  = S_IDLE;
                end
            end
            S_RDHEAD: begin
                o_cmd.op = lbtn_pkg::OP_RD_HEAD;
                n_state  = S_RDHCHK;
            end
            S_RDHCHK: begin
                if (i_stat.ok_rl) begin
                    o_cmd.op = lbtn_pkg::OP_RD_NODE;
                    n_state  = S_RDEMIT;
                end else begin
                    n_state = S_RDNEXT;
                end
            end
            S_RDEMIT: begin
                // hold while the previous value still waits for the output slot
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.op = lbtn_pkg::OP_RD_EMIT;
                    if (!i_stat.node_next_ok) n_state = S_RDNEXT;
                end
            end
            S_RDNEXT: begin
                if (i_stat.rl_lt_top) begin
                    o_cmd.op = lbtn_pkg::OP_RD_NEXTL;
                    n_state  = S_RDHEAD;
                end else begin
                    n_state = S_RDEND;
                end
            end
            S_RDEND: begin
                if (i_stat.out_free) begin
                    o_cmd.op = lbtn_pkg::OP_RD_END;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/lbtn_dp.sv
// Datapath of the keeper: registers, level heads, node pool, divider and output slot.
module lbtn_dp #(
    parameter int unsigned POOL_SIZE   = lbtn_pkg::POOL_SIZE_DEF,
    parameter int unsigned LEVEL_SLOTS = lbtn_pkg::LEVEL_SLOTS_DEF,
    parameter int unsigned SCORE_BITS  = lbtn_pkg::SCORE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lbtn_pkg::t_cmd                      i_cmd,
    output lbtn_pkg::t_stat                     o_stat,
    input  logic [lbtn_pkg::IN_DATA_W-1:0]      i_in_tdata,
    input  logic [lbtn_pkg::IN_USER_W-1:0]      i_in_tuser,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [31:0]                         i_cfg_wdata,
    output logic                                o_out_tvalid,
    input  logic                                i_out_tready,
    output logic [lbtn_pkg::OUT_DATA_W-1:0]     o_out_tdata,
    output logic [lbtn_pkg::OUT_USER_W-1:0]     o_out_tuser,
    output logic                                o_out_tlast
);

    localparam int PW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW  = $clog2(POOL_SIZE + 1);
    localparam int LW  = $clog2(LEVEL_SLOTS);
    localparam int EW  = (LW + 1 > 7) ? LW + 1 : 7;
    localparam int NW  = 32 + PW + 1;
    localparam int PRW = 32 + LW;
    localparam int SB  = SCORE_BITS;
    localparam logic [31:0] SMASK = (SB >= 32) ? 32'hffff_ffff
                                               : 32'((64'd1 << SB) - 64'd1);

    // configuration and store state
    logic [6:0]             r_keep;
    logic [6:0]             r_levels;
    logic [31:0]            r_width;
    logic [CW-1:0]          r_filled;
    logic [LW-1:0]          r_low;
    logic [SB-1:0]          r_base;
    logic [LEVEL_SLOTS-1:0] r_ok;

    // current item
    logic [1:0]             r_mode;
    logic [31:0]            r_score;
    logic [5:0]             r_given;
    logic [31:0]            r_val;
    logic [31:0]            r_rem;
    logic [31:0]            r_quo;
    logic [4:0]             r_cnt;
    logic [LW-1:0]          r_lvl;
    logic                   r_adm;
    logic                   r_ev;
    logic [31:0]            r_old;
    logic [PRW-1:0]         r_prod;

    // readout walk
    logic [LW-1:0]          r_rl;
    logic                   r_pend_v;
    logic [31:0]            r_pend_val;
    logic [LW-1:0]          r_pend_lvl;

    // memories and their read data
    logic [PW-1:0]          r_heads [LEVEL_SLOTS];
    logic [NW-1:0]          r_pool [POOL_SIZE];
    logic [PW-1:0]          r_hd_lvl;
    logic [PW-1:0]          r_hd_low;
    logic [NW-1:0]          r_node;

    // output slot
    logic                   r_ovalid;
    logic [lbtn_pkg::OUT_DATA_W-1:0] r_odata;
    logic [lbtn_pkg::OUT_USER_W-1:0] r_ouser;
    logic                   r_olast;

    logic [6:0]    w_keep_eff;
    logic [EW-1:0] w_lv;
    logic [EW-1:0] w_leff;
    logic [LW-1:0] w_top;
    logic [31:0]   w_wid;
    logic          w_below;
    logic [31:0]   w_nd_val;
    logic [PW-1:0] w_nd_next;
    logic          w_nd_nok;
    logic [32:0]   w_rsh;
    logic          w_ge;
    logic [32:0]   w_rsub;
    logic [LW-1:0] w_q_lvl;
    logic [LW-1:0] w_g_lvl;
    logic [LW-1:0] w_lvl_n;
    logic [63:0]   w_p64;
    logic          w_over;
    logic [SB-1:0] w_base_n;
    logic          w_out_free;

    logic          w_hwe;
    logic [LW-1:0] w_hwa;
    logic [PW-1:0] w_hwd;
    logic          w_hrea;
    logic          w_hreb;
    logic [LW-1:0] w_hrab;
    logic          w_pwe;
    logic [PW-1:0] w_pwa;
    logic [NW-1:0] w_pwd;
    logic          w_pre;
    logic [PW-1:0] w_pra;

    logic          w_push;
    logic [lbtn_pkg::OUT_DATA_W-1:0] w_pdata;
    logic [lbtn_pkg::OUT_USER_W-1:0] w_puser;
    logic          w_plast;

    assign w_keep_eff = (r_keep == 7'd0) ? 7'd1 :
                        (r_keep > 7'(POOL_SIZE)) ? 7'(POOL_SIZE) : r_keep;
    assign w_lv   = EW'(r_levels);
    assign w_leff = (w_lv == '0) ? EW'(1) :
                    (w_lv > EW'(LEVEL_SLOTS)) ? EW'(LEVEL_SLOTS) : w_lv;
    assign w_top  = LW'(w_leff - EW'(1));
    assign w_wid  = (r_width == 32'd0) ? 32'd1 : r_width;
    assign w_below = 7'(r_filled) < w_keep_eff;

    assign w_nd_val  = r_node[31:0];
    assign w_nd_next = r_node[32 +: PW];
    assign w_nd_nok  = r_node[NW-1];

    // one quotient bit per step
    assign w_rsh  = {r_rem, r_quo[31]};
    assign w_ge   = w_rsh >= {1'b0, w_wid};
    assign w_rsub = w_rsh - {1'b0, w_wid};

    assign w_q_lvl = (r_quo > 32'(w_top)) ? w_top : LW'(r_quo);
    assign w_g_lvl = (32'(r_given) > 32'(w_top)) ? w_top : LW'(r_given);
    assign w_lvl_n = (r_mode == lbtn_pkg::MODE_SCORE) ? w_q_lvl : w_g_lvl;

    // saturate the base score at the score range
    assign w_p64    = 64'(r_prod);
    assign w_over   = (w_p64 >> SB) != 64'd0;
    assign w_base_n = w_over ? '1 : SB'(w_p64);

    assign w_out_free = !r_ovalid || i_out_tready;

    assign o_stat.mode         = r_mode;
    assign o_stat.div_last     = (r_cnt == 5'd31);
    assign o_stat.drop         = (r_mode == lbtn_pkg::MODE_SCORE) &&
                                 (64'(r_score) < 64'(r_base));
    assign o_stat.below_cap    = w_below;
    assign o_stat.can_evict    = (r_low < r_lvl) && r_ok[r_low];
    assign o_stat.ok_low       = r_ok[r_low];
    assign o_stat.walk         = (r_low < w_top) && !r_ok[r_low];
    assign o_stat.ok_rl        = r_ok[r_rl];
    assign o_stat.rl_lt_top    = r_rl < w_top;
    assign o_stat.node_next_ok = w_nd_nok;
    assign o_stat.pend_valid   = r_pend_v;
    assign o_stat.out_free     = w_out_free;

    // memory port steering
    always_comb begin
        w_hwe  = 1'b0;
        w_hwa  = r_lvl;
        w_hwd  = r_hd_low;
        w_hrea = 1'b0;
        w_hreb = 1'b0;
        w_hrab = r_low;
        w_pwe  = 1'b0;
        w_pwa  = r_hd_low;
        w_pwd  = {r_ok[r_lvl], r_hd_lvl, r_val};
        w_pre  = 1'b0;
        w_pra  = r_hd_low;
        unique case (i_cmd.op)
            lbtn_pkg::OP_LVL: begin
                w_hrea = 1'b1;
                w_hreb = 1'b1;
            end
            lbtn_pkg::OP_FILL: begin
                w_hwe = 1'b1;
                w_hwd = PW'(r_filled);
                w_pwe = 1'b1;
                w_pwa = PW'(r_filled);
            end
            lbtn_pkg::OP_EVRD: w_pre = 1'b1;
            lbtn_pkg::OP_EVICT: begin
                w_hwe = 1'b1;
                w_pwe = 1'b1;
            end
            lbtn_pkg::OP_EVICT2: begin
                w_hwe = 1'b1;
                w_hwa = r_low;
                w_hwd = w_nd_next;
            end
            lbtn_pkg::OP_RD_HEAD: begin
                w_hreb = 1'b1;
                w_hrab = r_rl;
            end
            lbtn_pkg::OP_RD_NODE: w_pre = 1'b1;
            lbtn_pkg::OP_RD_EMIT: begin
                w_pre = w_nd_nok;
                w_pra = w_nd_next;
            end
            default: ;
        endcase
    end

    // result push
    always_comb begin
        w_push  = 1'b0;
        w_pdata = '0;
        w_puser = '0;
        w_plast = 1'b1;
        unique case (i_cmd.op)
            lbtn_pkg::OP_RES_INS: begin
                w_push  = 1'b1;
                w_pdata = {4'd0, 6'(r_low), 6'(r_lvl), r_old};
                w_puser = {1'b0, r_ev, r_adm};
            end
            lbtn_pkg::OP_RES_CLR: begin
                w_push  = 1'b1;
                w_pdata = {4'd0, 6'(r_low), 6'd0, 32'd0};
            end
            lbtn_pkg::OP_RD_EMIT: begin
                w_push  = r_pend_v;
                w_pdata = {4'd0, 6'(r_low), 6'(r_pend_lvl), r_pend_val};
                w_puser = 3'b100;
                w_plast = 1'b0;
            end
            lbtn_pkg::OP_RD_END: begin
                w_push = 1'b1;
                if (r_pend_v) begin
                    w_pdata = {4'd0, 6'(r_low), 6'(r_pend_lvl), r_pend_val};
                    w_puser = 3'b100;
                end else begin
                    w_pdata = {4'd0, 6'(r_low), 6'd0, 32'd0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) r_heads[w_hwa] <= w_hwd;
        if (w_hrea) r_hd_lvl <= r_heads[w_lvl_n];
        if (w_hreb) r_hd_low <= r_heads[w_hrab];
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) r_pool[w_pwa] <= w_pwd;
        if (w_pre) r_node <= r_pool[w_pra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep   <= 7'd64;
            r_levels <= 7'd64;
            r_width  <= 32'd1;
            r_filled <= '0;
            r_low    <= '0;
            r_base   <= '0;
            r_ok     <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index == lbtn_pkg::CFG_KEEP ||
                             i_cfg_index == lbtn_pkg::CFG_LEVELS ||
                             i_cfg_index == lbtn_pkg::CFG_WIDTH)) begin
                // any register write restarts the store
                if (i_cfg_index == lbtn_pkg::CFG_KEEP)   r_keep   <= i_cfg_wdata[6:0];
                if (i_cfg_index == lbtn_pkg::CFG_LEVELS) r_levels <= i_cfg_wdata[6:0];
                if (i_cfg_index == lbtn_pkg::CFG_WIDTH)  r_width  <= i_cfg_wdata;
                r_filled <= '0;
                r_low    <= '0;
                r_base   <= '0;
                r_ok     <= '0;
            end else begin
                unique case (i_cmd.op)
                    lbtn_pkg::OP_LOAD:   r_pend_v <= 1'b0;
                    lbtn_pkg::OP_FILL: begin
                        r_ok[r_lvl] <= 1'b1;
                        r_filled    <= r_filled + CW'(1);
                    end
                    lbtn_pkg::OP_EVICT:  r_ok[r_lvl] <= 1'b1;
                    lbtn_pkg::OP_EVICT2: r_ok[r_low] <= w_nd_nok;
                    lbtn_pkg::OP_CLAMP:  if (r_low > w_top) r_low <= w_top;
                    lbtn_pkg::OP_ADV:    r_low <= r_low + LW'(1);
                    lbtn_pkg::OP_BASE:   r_base <= w_base_n;
                    lbtn_pkg::OP_CLEAR: begin
                        r_filled <= '0;
                        r_low    <= '0;
                        r_base   <= '0;
                        r_ok     <= '0;
                    end
                    lbtn_pkg::OP_RD_EMIT: r_pend_v <= 1'b1;
                    lbtn_pkg::OP_RD_END:  r_pend_v <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_odata <= w_pdata;
            r_ouser <= w_puser;
            r_olast <= w_plast;
        end
        unique case (i_cmd.op)
            lbtn_pkg::OP_LOAD: begin
                r_mode  <= i_in_tuser;
                r_score <= i_in_tdata[31:0] & SMASK;
                r_given <= i_in_tdata[37:32];
                r_val   <= i_in_tdata[69:38];
                r_rem   <= '0;
                r_quo   <= i_in_tdata[31:0] & SMASK;
                r_cnt   <= '0;
                r_adm   <= 1'b0;
                r_ev    <= 1'b0;
                r_old   <= '0;
            end
            lbtn_pkg::OP_DIV: begin
                r_rem <= w_ge ? w_rsub[31:0] : w_rsh[31:0];
                r_quo <= {r_quo[30:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            lbtn_pkg::OP_LVL:  r_lvl <= w_lvl_n;
            lbtn_pkg::OP_FILL: r_adm <= 1'b1;
            lbtn_pkg::OP_EVICT: begin
                r_adm <= 1'b1;
                r_ev  <= 1'b1;
                r_old <= w_nd_val;
            end
            lbtn_pkg::OP_MUL:      r_prod <= PRW'(w_wid) * PRW'(r_low);
            lbtn_pkg::OP_RD_START: r_rl <= r_low;
            lbtn_pkg::OP_RD_NEXTL: r_rl <= r_rl + LW'(1);
            lbtn_pkg::OP_RD_EMIT: begin
                r_pend_val <= w_nd_val;
                r_pend_lvl <= r_rl;
            end
            default: ;
        endcase
    end

    assign o_out_tvalid = r_ovalid;
    assign o_out_tdata  = r_odata;
    assign o_out_tuser  = r_ouser;
    assign o_out_tlast  = r_olast;

endmodule

### tb/sv/level_bucketed_top_n_keeper_tb.sv
// Self-checking testbench for the level bucketed top-N keeper.
`timescale 1ns / 100ps

class lbtn_scoreboard;
    // configuration copy
    int unsigned keep_reg, levels_reg, width_reg;
    // store copy
    int unsigned filled, low_lvl;
    longint unsigned low_base;
    int unsigned head [64];
    bit          head_ok [64];
    logic [31:0] node_val [64];
    int unsigned node_next [64];
    bit          node_next_ok [64];
    // expected results: {last, out_valid, evicted, admitted, lowest, level, value}
    logic [47:0] exp_q [$];
    int          errors;

    function new();
        keep_reg = 64; levels_reg = 64; width_reg = 1; errors = 0;
        wipe();
    endfunction

    function void wipe();
        filled = 0; low_lvl = 0; low_base = 0;
        foreach (head_ok[i]) begin head[i] = 0; head_ok[i] = 0; end
    endfunction

    function int unsigned n_keep();
        return keep_reg < 1 ? 1 : (keep_reg > 64 ? 64 : keep_reg);
    endfunction

    function int unsigned top_lvl();
        return (levels_reg < 1 ? 1 : (levels_reg > 64 ? 64 : levels_reg)) - 1;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] v);
        if (idx == lbtn_pkg::CFG_KEEP) keep_reg = v[6:0];
        else if (idx == lbtn_pkg::CFG_LEVELS) levels_reg = v[6:0];
        else if (idx == lbtn_pkg::CFG_WIDTH) width_reg = v;
        else return;
        wipe();
    endfunction

    function void push_res(bit a, bit e, bit ok, logic [31:0] v, int unsigned l, bit lst);
        exp_q.push_back({lst, ok, e, a, 6'(low_lvl), 6'(l), v});
    endfunction

    function void raise_low();
        longint unsigned w, b;
        int unsigned t;
        t = top_lvl();
        w = (width_reg == 0) ? 1 : width_reg;
        if (low_lvl > t) low_lvl = t;
        if (head_ok[low_lvl]) return;
        while (low_lvl < t && !head_ok[low_lvl]) low_lvl++;
        b = w * low_lvl;
        low_base = b > 64'hffffffff ? 64'hffffffff : b;
    endfunction

    function void place(int unsigned lvl, logic [31:0] v);
        int unsigned idx;
        logic [31:0] old;
        if (filled < n_keep()) begin
            idx = filled % 64;
            node_val[idx] = v; node_next[idx] = head[lvl]; node_next_ok[idx] = head_ok[lvl];
            head[lvl] = idx; head_ok[lvl] = 1; filled++;
            if (filled >= n_keep()) raise_low();
            push_res(1, 0, 0, 0, lvl, 1);
        end else if (low_lvl < lvl && head_ok[low_lvl]) begin
            idx = head[low_lvl];
            old = node_val[idx];
            head[low_lvl] = node_next[idx]; head_ok[low_lvl] = node_next_ok[idx];
            node_next[idx] = head[lvl]; node_next_ok[idx] = head_ok[lvl];
            node_val[idx] = v; head[lvl] = idx; head_ok[lvl] = 1;
            raise_low();
            push_res(1, 1, 0, old, lvl, 1);
        end else begin
            push_res(0, 0, 0, 0, lvl, 1);
        end
    endfunction

    function void note_item(logic [1:0] mode, logic [31:0] score, logic [5:0] glvl,
                            logic [31:0] v);
        int unsigned t, lvl, idx, k, l;
        longint unsigned w, q;
        bit ok;
        t = top_lvl();
        case (mode)
            lbtn_pkg::MODE_SCORE: begin
                w = (width_reg == 0) ? 1 : width_reg;
                q = longint'(score) / w;
                lvl = (q > t) ? t : 32'(q);
                if (score < low_base) push_res(0, 0, 0, 0, lvl, 1);
                else place(lvl, v);
            end
            lbtn_pkg::MODE_LEVEL: place(glvl > t ? t : glvl, v);
            lbtn_pkg::MODE_CLEAR: begin
                wipe();
                push_res(0, 0, 0, 0, 0, 1);
            end
            default: begin
                k = 0;
                for (l = low_lvl; l <= t; l++) begin
                    idx = head[l]; ok = head_ok[l];
                    while (ok && k < 64) begin
                        push_res(0, 0, 1, node_val[idx], l, 0);
                        k++;
                        ok = node_next_ok[idx]; idx = node_next[idx];
                    end
                end
                if (k == 0) push_res(0, 0, 0, 0, 0, 1);
                else exp_q[$][47] = 1;
            end
        endcase
    endfunction

    function void check_result(logic [47:0] data, logic [2:0] user, logic lst);
        logic [47:0] e, got;
        got = {lst, user, data[43:0]};
        if (exp_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        e = exp_q.pop_front();
        if (got !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", e, got);
        end
    endfunction
endclass

module level_bucketed_top_n_keeper_tb;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid, m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;

    lbtn_scoreboard keeper_sb;
    bit  calm;          // no idling in the final stretch
    int  quiet_cycles = 0;

    level_bucketed_top_n_keeper i_dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // output side: random stall bursts, check every accepted result
    initial begin
        int stall;
        m_axis_tready = 0;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 15);
                m_axis_tready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                keeper_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // valid stays up after an accept until the next item or a drain replaces it
    task automatic send_item(logic [1:0] mode, logic [31:0] score, logic [5:0] glvl,
                             logic [31:0] v);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b0, v, glvl, score};
        do @(posedge i_clk); while (!s_axis_tready);
        keeper_sb.note_item(mode, score, glvl, v);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (keeper_sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] v);
        drain();
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        keeper_sb.write_reg(idx, v);
    endtask

    task automatic rand_item(int unsigned wmax);
        int unsigned r;
        logic [31:0] sc;
        r = $urandom_range(0, 99);
        sc = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, wmax);
        if (r < 45)
            send_item(lbtn_pkg::MODE_SCORE, sc, 6'($urandom()), $urandom());
        else if (r < 85)
            send_item(lbtn_pkg::MODE_LEVEL, $urandom(), 6'($urandom()), $urandom());
        else if (r < 89)
            send_item(lbtn_pkg::MODE_CLEAR, $urandom(), 6'($urandom()), $urandom());
        else
            send_item(lbtn_pkg::MODE_READ, $urandom(), 6'($urandom()), $urandom());
    endtask

    initial begin
        int ph;
        keeper_sb = new();
        calm = 0;
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        i_cfg_we = 0; i_cfg_index = lbtn_pkg::CFG_KEEP; i_cfg_wdata = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty readout, extremes, fill small store, evictions
        send_item(lbtn_pkg::MODE_READ, 0, 0, 0);
        write_cfg(lbtn_pkg::CFG_KEEP, 3);
        write_cfg(lbtn_pkg::CFG_LEVELS, 8);
        write_cfg(lbtn_pkg::CFG_WIDTH, 10);
        send_item(lbtn_pkg::MODE_SCORE, 32'hffffffff, 6'h3f, 32'h7fffffff);
        send_item(lbtn_pkg::MODE_SCORE, 0, 0, 32'h80000000);
        send_item(lbtn_pkg::MODE_LEVEL, 0, 6'h3f, 32'hffffffff);
        send_item(lbtn_pkg::MODE_SCORE, 5, 0, 1);
        send_item(lbtn_pkg::MODE_SCORE, 25, 0, 2);
        send_item(lbtn_pkg::MODE_LEVEL, 0, 3, 3);
        send_item(lbtn_pkg::MODE_LEVEL, 0, 5, 4);
        send_item(lbtn_pkg::MODE_SCORE, 1, 0, 5);
        send_item(lbtn_pkg::MODE_READ, 0, 0, 0);
        send_item(lbtn_pkg::MODE_CLEAR, 32'hffffffff, 6'h3f, 32'hffffffff);
        send_item(lbtn_pkg::MODE_READ, 0, 0, 0);
        write_cfg(lbtn_pkg::CFG_WIDTH, 0);
        write_cfg(lbtn_pkg::CFG_KEEP, 0);
        write_cfg(lbtn_pkg::CFG_LEVELS, 0);
        send_item(lbtn_pkg::MODE_SCORE, 7, 0, 6);
        send_item(lbtn_pkg::MODE_LEVEL, 0, 9, 7);
        send_item(lbtn_pkg::MODE_READ, 0, 0, 0);
        write_cfg(lbtn_pkg::CFG_LEVELS, 127);
        write_cfg(lbtn_pkg::CFG_WIDTH, 32'hffffffff);
        write_cfg(lbtn_pkg::CFG_KEEP, 1);
        send_item(lbtn_pkg::MODE_SCORE, 32'hfffffffe, 0, 8);
        send_item(lbtn_pkg::MODE_LEVEL, 0, 1, 9);
        send_item(lbtn_pkg::MODE_READ, 0, 0, 0);

        // random phases over several settings
        for (ph = 0; ph < 6; ph++) begin
            int unsigned wd;
            wd = (ph == 5) ? 32'h80000000 : $urandom_range(1, 40);
            write_cfg(lbtn_pkg::CFG_KEEP, (ph == 0) ? 64 : $urandom_range(1, 20));
            write_cfg(lbtn_pkg::CFG_LEVELS, (ph == 1) ? 64 : $urandom_range(2, 16));
            write_cfg(lbtn_pkg::CFG_WIDTH, wd);
            if (ph == 5) calm = 1;
            repeat (58) rand_item((wd > 1000) ? 32'hffffffff : wd * 20);
            send_item(lbtn_pkg::MODE_READ, 0, 0, 0);
        end

        drain();
        if (keeper_sb.errors == 0 && keeper_sb.exp_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
